[sv/websocket_frame_unmasker_defines.svh]
// assertion macros for the websocket frame unmasker
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wsfu_pkg.sv]
// shared types and constants for the websocket frame unmasker
package wsfu_pkg;

    localparam logic [7:0] MASK_FLAG = 8'h80;
    localparam logic [7:0] LEN_MASK  = 8'h7f;

    typedef enum logic [3:0] {
        PH_HDR0 = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_KEY  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       empty_frame;
        logic       was_masked;
    } result_t;

endpackage

[sv/wsfu_ifs.sv]
// stream channels for raw frame bytes and unmasked payload beats
interface wsfu_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;

    modport source (output valid, output frame_byte, input ready);
    modport sink   (input valid, input frame_byte, output ready);
endinterface

interface wsfu_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic       was_masked;

    modport source (output valid, output payload_byte, output last_of_frame,
                    output empty_frame, output was_masked, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame,
                    input empty_frame, input was_masked, output ready);
endinterface

[sv/wsfu_in_stage.sv]
// input register for raw frame bytes
module wsfu_in_stage
    import wsfu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wsfu_frame_if.sink   frame,
    input  logic         take,
    output beat_t        beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign frame.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (frame.ready)
        begin
            valid_next = frame.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            data_reg <= frame.frame_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

[sv/wsfu_parser.sv]
// frame header parser, mask key store and payload unmasking
`include "websocket_frame_unmasker_defines.svh"

module wsfu_parser
    import wsfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  beat_t   beat,
    input  logic    out_free,
    output logic    take,
    output result_t res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic        masked_reg;
    logic        masked_next;
    logic [6:0]  left_reg;
    logic [6:0]  left_next;
    logic [1:0]  kpos_reg;
    logic [1:0]  kpos_next;
    logic [7:0]  len_field;
    logic [7:0]  key_byte;
    logic [6:0]  left_dec;

    assign len_field = beat.data & LEN_MASK;
    assign left_dec  = left_reg - 7'd1;
    assign key_byte  = masked_reg ? key_reg[{kpos_reg, 3'b000} +: 8] : 8'h00;

    always_comb
    begin
        phase_next  = phase_reg;
        key_next    = key_reg;
        masked_next = masked_reg;
        left_next   = left_reg;
        kpos_next   = kpos_reg;
        res         = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                masked_next = (beat.data & MASK_FLAG) != 8'h00;
                left_next   = len_field[6:0];
                kpos_next   = 2'd0;
                if (masked_next)
                begin
                    phase_next = PH_KEY;
                end
                else if (left_next == 7'd0)
                begin
                    phase_next        = PH_HDR0;
                    res.valid         = beat.valid;
                    res.last_of_frame = 1'b1;
                    res.empty_frame   = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_KEY:
            begin
                key_next[{kpos_reg, 3'b000} +: 8] = beat.data;
                kpos_next = kpos_reg + 2'd1;
                if (kpos_reg == 2'd3)
                begin
                    if (left_reg == 7'd0)
                    begin
                        phase_next        = PH_HDR0;
                        res.valid         = beat.valid;
                        res.last_of_frame = 1'b1;
                        res.empty_frame   = 1'b1;
                        res.was_masked    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                kpos_next         = kpos_reg + 2'd1;
                left_next         = left_dec;
                res.valid         = beat.valid;
                res.payload_byte  = beat.data ^ key_byte;
                res.last_of_frame = left_dec == 7'd0;
                res.was_masked    = masked_reg;
                if (left_dec == 7'd0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_LEN;
            end
        endcase
    end

    assign take = beat.valid && (!res.valid || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            key_reg    <= '0;
            masked_reg <= 1'b0;
            left_reg   <= '0;
            kpos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            key_reg    <= key_next;
            masked_reg <= masked_next;
            left_reg   <= left_next;
            kpos_reg   <= kpos_next;
        end
    end

    `WSFU_ASSERT_NOW(a_empty_is_last, res.valid && res.empty_frame,
        res.last_of_frame && res.payload_byte == 8'h00, "empty marker not last")
    `WSFU_ASSERT_NOW(a_data_has_count, phase_reg == PH_DATA, left_reg != 7'd0,
        "payload phase with no bytes left")
    `WSFU_ASSERT_NOW(a_data_gives_beat, beat.valid && phase_reg == PH_DATA, res.valid,
        "payload byte without result")
    `WSFU_ASSERT_NEXT(a_last_ends_frame, take && res.valid && res.last_of_frame,
        phase_reg == PH_HDR0, "frame end did not return to header")

endmodule

[sv/wsfu_out_stage.sv]
// result register driving the payload channel
module wsfu_out_stage
    import wsfu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  result_t        res,
    output logic           out_free,
    wsfu_payload_if.source payload
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || payload.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            data_reg <= res;
        end
    end

    assign payload.valid         = valid_reg;
    assign payload.payload_byte  = data_reg.payload_byte;
    assign payload.last_of_frame = data_reg.last_of_frame;
    assign payload.empty_frame   = data_reg.empty_frame;
    assign payload.was_masked    = data_reg.was_masked;

endmodule

[sv/websocket_frame_unmasker.sv]
// a payload byte is registered at the input, unmasked, then registered again at the output
// throughput: one frame byte per cycle unless output stalls; parsed between two registers
// header and key bytes produce no beat, except the marker beat that ends an empty frame
// reset: asynchronous, active low; returns to waiting for the first header byte, key cleared
// top level of the websocket frame unmasker
module websocket_frame_unmasker
    import wsfu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    wsfu_frame_if.sink     frame,
    wsfu_payload_if.source payload
);

    beat_t   beat;
    result_t res;
    logic    take;
    logic    out_free;

    wsfu_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .take  (take),
        .beat  (beat)
    );

    wsfu_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .out_free (out_free),
        .take     (take),
        .res      (res)
    );

    wsfu_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .out_free (out_free),
        .payload  (payload)
    );

endmodule

[tb/websocket_frame_unmasker_test.sv]
// self-checking testbench for the websocket frame unmasker: directed and random frames
module websocket_frame_unmasker_test;
    import wsfu_pkg::*;

    localparam int STALL_PCT   = 17;
    localparam int RANDOM_BYTES = 950;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    class unmask_tracker;
        phase_t      parse_phase;
        logic [31:0] key;
        logic        masked;
        logic [6:0]  left;
        logic [1:0]  key_idx;
        result_t     expected_beats[$];
        int          mismatches;
        int          beats_checked;
        int          frames;
        int          masked_frames;
        int          empty_frames;

        function new();
            parse_phase   = PH_HDR0;
            key           = '0;
            masked        = 1'b0;
            left          = '0;
            key_idx       = '0;
            mismatches    = 0;
            beats_checked = 0;
            frames        = 0;
            masked_frames = 0;
            empty_frames  = 0;
        endfunction

        function void push_beat(logic [7:0] data, logic last, logic empty, logic wm);
            result_t r;
            r.valid         = 1'b1;
            r.payload_byte  = data;
            r.last_of_frame = last;
            r.empty_frame   = empty;
            r.was_masked    = wm;
            expected_beats.push_back(r);
            if (empty)
                empty_frames++;
        endfunction

        function void take_frame_byte(logic [7:0] b);
            logic [7:0] key_byte;
            case (parse_phase)
                PH_LEN:
                begin
                    frames++;
                    masked  = (b & MASK_FLAG) != 8'h00;
                    left    = 7'(b & LEN_MASK);
                    key_idx = '0;
                    if (masked)
                    begin
                        masked_frames++;
                        parse_phase = PH_KEY;
                    end
                    else if (left == 7'd0)
                    begin
                        parse_phase = PH_HDR0;
                        push_beat(8'h00, 1'b1, 1'b1, 1'b0);
                    end
                    else
                        parse_phase = PH_DATA;
                end
                PH_KEY:
                begin
                    key[8*key_idx +: 8] = b;
                    key_idx = key_idx + 2'd1;
                    if (key_idx == 2'd0)
                    begin
                        if (left == 7'd0)
                        begin
                            parse_phase = PH_HDR0;
                            push_beat(8'h00, 1'b1, 1'b1, 1'b1);
                        end
                        else
                            parse_phase = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    key_byte = masked ? key[8*key_idx +: 8] : 8'h00;
                    key_idx  = key_idx + 2'd1;
                    left     = left - 7'd1;
                    push_beat(b ^ key_byte, left == 7'd0, 1'b0, masked);
                    if (left == 7'd0)
                        parse_phase = PH_HDR0;
                end
                default:
                    parse_phase = PH_LEN;
            endcase
        endfunction

        function void check_payload_beat(logic [7:0] data, logic last, logic empty, logic wm);
            result_t e;
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected beat: byte %02h last %b empty %b masked %b",
                             $time, data, last, empty, wm);
                return;
            end
            e = expected_beats.pop_front();
            if (e.payload_byte !== data || e.last_of_frame !== last
                || e.empty_frame !== empty || e.was_masked !== wm)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t beat mismatch: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                             $time, e.payload_byte, e.last_of_frame, e.empty_frame,
                             e.was_masked, data, last, empty, wm);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wsfu_frame_if   frame_ch();
    wsfu_payload_if payload_ch();

    websocket_frame_unmasker dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .payload (payload_ch)
    );

    unmask_tracker book;
    int            bytes_in;
    int            idle_cycles;
    bit            no_stall;

    logic [7:0] opening_bytes [24] = '{
        8'hff, 8'h00,
        8'h00, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h81, 8'h03, 8'h00, 8'hff, 8'h5a,
        8'h82, 8'h85, 8'h00, 8'hff, 8'ha5, 8'h5a, 8'hff, 8'h00, 8'hff, 8'h00, 8'h3c
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        payload_ch.ready = no_stall || ($urandom_range(0, 99) >= STALL_PCT);

    always @(posedge clk)
    begin
        if (rst_n && payload_ch.valid && payload_ch.ready)
            book.check_payload_beat(payload_ch.payload_byte, payload_ch.last_of_frame,
                                    payload_ch.empty_frame, payload_ch.was_masked);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready)
            || (payload_ch.valid && payload_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        no_stall = bytes_in >= 400 && bytes_in < 600;
        while (!no_stall && $urandom_range(0, 99) < STALL_PCT)
        begin
            frame_ch.valid = 1'b0;
            @(negedge clk);
        end
        frame_ch.valid      = 1'b1;
        frame_ch.frame_byte = b;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        book.take_frame_byte(b);
        bytes_in++;
        @(negedge clk);
    endtask

    task automatic drain_beats();
        frame_ch.valid = 1'b0;
        while (book.expected_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_random_frame();
        logic       with_key;
        int         sel;
        int         len;
        with_key = 1'($urandom_range(0, 1));
        sel      = $urandom_range(0, 99);
        if (sel < 8)
            len = 0;
        else if (sel < 14)
            len = $urandom_range(126, 127);
        else if (sel < 20)
            len = $urandom_range(0, 127);
        else
            len = $urandom_range(1, 10);
        send_byte(8'($urandom_range(0, 255)));
        send_byte({with_key, 7'(len)});
        if (with_key)
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int frame_no;
        book                  = new();
        rst_n                 = 1'b0;
        frame_ch.valid        = 1'b0;
        frame_ch.frame_byte   = 8'h00;
        bytes_in              = 0;
        no_stall              = 1'b0;
        frame_no              = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        drain_beats();

        while (bytes_in < RANDOM_BYTES + 24)
        begin
            send_random_frame();
            frame_no++;
            if (frame_no == 15)
                drain_beats();
        end

        drain_beats();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("frames %0d (masked %0d, empty %0d), frame bytes %0d, payload beats %0d",
                 book.frames, book.masked_frames, book.empty_frames, bytes_in,
                 book.beats_checked);
        if (book.mismatches == 0 && book.expected_beats.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("mismatches %0d, beats still expected %0d",
                     book.mismatches, book.expected_beats.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
